// ----- design/tlcmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcmc_pkg
// shared widths, register map, reset values and outcome codes of the
// two-level cache miss classifier
// ----------------------------------------------------------------------------
package tlcmc_pkg;

    localparam int DEF_ADDR_BITS       = 16;
    localparam int DEF_L1_MAX_ENTRIES  = 64;
    localparam int DEF_L2_MAX_ENTRIES  = 512;
    localparam int DEF_MAX_BLOCK_BYTES = 256;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 3;
    localparam int L1_ENT_W  = 7;
    localparam int L1_WAY_W  = 7;
    localparam int L2_ENT_W  = 10;
    localparam int L2_WAY_W  = 10;
    localparam int BLK_W     = 9;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    typedef logic [OUT_W-1:0]     outcome_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_L1_LINES    = 3'd0;
    localparam reg_idx_t REG_L1_WAYS     = 3'd1;
    localparam reg_idx_t REG_L2_LINES    = 3'd2;
    localparam reg_idx_t REG_L2_WAYS     = 3'd3;
    localparam reg_idx_t REG_BLOCK_BYTES = 3'd4;

    localparam logic [L1_ENT_W-1:0] RST_L1_LINES    = 7'd16;
    localparam logic [L1_WAY_W-1:0] RST_L1_WAYS     = 7'd2;
    localparam logic [L2_ENT_W-1:0] RST_L2_LINES    = 10'd128;
    localparam logic [L2_WAY_W-1:0] RST_L2_WAYS     = 10'd4;
    localparam logic [BLK_W-1:0]    RST_BLOCK_BYTES = 9'd16;

    localparam outcome_t OUT_HIT_L1     = 3'd0;
    localparam outcome_t OUT_HIT_L2     = 3'd1;
    localparam outcome_t OUT_COMPULSORY = 3'd2;
    localparam outcome_t OUT_CONFLICT   = 3'd3;
    localparam outcome_t OUT_CAPACITY   = 3'd4;
    localparam outcome_t OUT_BAD_CFG    = 3'd5;

endpackage

// ----- design/two_level_cache_miss_classifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_cache_miss_classifier_unit
// classifies each byte address as L1 hit, L2 hit, compulsory, conflict or
// capacity miss against set-associative tag memories and a reference store,
// or reports a bad configuration
//   channel   signals                              direction
//   in        in_valid, in_ready, byte_address     into the block
//   out       out_valid, out_ready, outcome        out of the block
//   cfg       psel, penable, pwrite, paddr,        register access
//             pwdata, prdata, pready
//
// steps: take the address, up to five divisions on the shared radix-2
//   divider (DW = max(ADDR_BITS,10) quotient bits each), the set bases, then
//   the tag memory scans, which read one way or reference entry per cycle,
//   up to three fill steps and the load of the output register
// reset and any write to one of the five registers run a clearing pass over
//   all memories, indexed by a CLR_W-bit counter; no address is taken meanwhile
// one address is in work at a time; a finished outcome waits in the output
//   register while the next address is taken, and the next outcome holds
//   until that register is free
// ----------------------------------------------------------------------------
module two_level_cache_miss_classifier_unit
    import tlcmc_pkg::*;
#(
    parameter int ADDR_BITS       = DEF_ADDR_BITS,
    parameter int L1_MAX_ENTRIES  = DEF_L1_MAX_ENTRIES,
    parameter int L2_MAX_ENTRIES  = DEF_L2_MAX_ENTRIES,
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [IN_W-1:0]    byte_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [OUT_W-1:0]   outcome,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int L1_AW   = (L1_MAX_ENTRIES > 1) ? $clog2(L1_MAX_ENTRIES) : 1;
    localparam int L2_AW   = (L2_MAX_ENTRIES > 1) ? $clog2(L2_MAX_ENTRIES) : 1;
    localparam int SEEN_AW = ADDR_BITS - 5;
    localparam int CLR_W   = (L1_AW > L2_AW) ?
                             ((L1_AW > SEEN_AW) ? L1_AW : SEEN_AW) :
                             ((L2_AW > SEEN_AW) ? L2_AW : SEEN_AW);
    localparam int TAG_W   = ADDR_BITS;
    localparam int LINE_W  = TAG_W + 1;
    localparam int DW      = (ADDR_BITS > 10) ? ADDR_BITS : 10;
    localparam int DCW     = $clog2(DW + 1);
    localparam int SW1     = $clog2(L1_MAX_ENTRIES + 1);
    localparam int SW2     = $clog2(L2_MAX_ENTRIES + 1);
    localparam int SW      = (SW1 > SW2) ? SW1 : SW2;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_BASE  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_FILLR = 4'd5;
    localparam logic [3:0] S_FILL2 = 4'd6;
    localparam logic [3:0] S_FILL1 = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam logic [2:0] DIV_S1   = 3'd0;
    localparam logic [2:0] DIV_S2   = 3'd1;
    localparam logic [2:0] DIV_BLK  = 3'd2;
    localparam logic [2:0] DIV_SET1 = 3'd3;
    localparam logic [2:0] DIV_SET2 = 3'd4;

    localparam logic [1:0] SEL_L1  = 2'd0;
    localparam logic [1:0] SEL_L2  = 2'd1;
    localparam logic [1:0] SEL_REF = 2'd2;

    // configuration registers
    logic [L1_ENT_W-1:0] l1_lines_reg;
    logic [L1_WAY_W-1:0] l1_ways_reg;
    logic [L2_ENT_W-1:0] l2_lines_reg;
    logic [L2_WAY_W-1:0] l2_ways_reg;
    logic [BLK_W-1:0]    block_bytes_reg;

    // control
    logic [3:0]       state_reg;
    logic [CLR_W-1:0] clr_cnt_reg;
    logic [2:0]       step_reg;
    logic             out_valid_reg;
    outcome_t         outcome_reg;
    outcome_t         code_reg;

    // divider
    logic [DW-1:0]  div_q_reg;
    logic [DW:0]    div_r_reg;
    logic [DW-1:0]  div_d_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic [DW:0]    div_trial;
    logic           div_ge;

    // per-item values
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] blk_reg;
    logic [L1_ENT_W-1:0]  s1_reg;
    logic [L2_ENT_W-1:0]  s2_reg;
    logic [L1_AW-1:0]     set1_reg;
    logic [L2_AW-1:0]     set2_reg;
    logic [TAG_W-1:0]     tag1_reg;
    logic [TAG_W-1:0]     tag2_reg;
    logic [L1_AW-1:0]     base1_reg;
    logic [L2_AW-1:0]     base2_reg;

    // scan
    logic [1:0]  scan_sel_reg;
    logic [SW-1:0] issue_idx_reg;
    logic        pend_reg;
    logic [SW-1:0] pend_way_reg;
    logic        hit_reg;
    logic        inv_found_reg;
    logic [SW-1:0] inv_way_reg;
    logic        l1_inv_found_reg;
    logic [SW-1:0] l1_inv_way_reg;
    logic        l2_inv_found_reg;
    logic [SW-1:0] l2_inv_way_reg;
    logic [L1_AW-1:0] ref_ptr_reg;

    logic [SW-1:0]     ways_cur;
    logic [TAG_W-1:0]  tag_cur;
    logic [LINE_W-1:0] rd_line;
    logic              scan_issue;
    logic              scan_done;
    logic              seen_bit;
    logic              cfg_wr;
    logic              cfg_static_bad;

    // memories
    logic [LINE_W-1:0] l1_mem  [0:(1 << L1_AW)-1];
    logic [LINE_W-1:0] l2_mem  [0:(1 << L2_AW)-1];
    logic [LINE_W-1:0] ref_mem [0:(1 << L1_AW)-1];
    logic [L1_AW-1:0]  l1p_mem [0:(1 << L1_AW)-1];
    logic [L2_AW-1:0]  l2p_mem [0:(1 << L2_AW)-1];
    logic [31:0]       seen_mem [0:(1 << SEEN_AW)-1];

    logic [LINE_W-1:0] l1_rd_reg;
    logic [LINE_W-1:0] l2_rd_reg;
    logic [LINE_W-1:0] ref_rd_reg;
    logic [L1_AW-1:0]  l1p_rd_reg;
    logic [L2_AW-1:0]  l2p_rd_reg;
    logic [31:0]       seen_rd_reg;

    logic              l1_we, l2_we, ref_we, l1p_we, l2p_we, seen_we;
    logic [L1_AW-1:0]  l1_wa, ref_wa, l1p_wa;
    logic [L2_AW-1:0]  l2_wa, l2p_wa;
    logic [SEEN_AW-1:0] seen_wa;
    logic [LINE_W-1:0] l1_wd, l2_wd, ref_wd;
    logic [L1_AW-1:0]  l1p_wd;
    logic [L2_AW-1:0]  l2p_wd;
    logic [31:0]       seen_wd;
    logic [L1_AW-1:0]  l1_ra, ref_ra;
    logic [L2_AW-1:0]  l2_ra;

    // victim selection
    logic [SW-1:0] l1_v, l1_way, l1_ptr_new;
    logic [SW-1:0] l2_v, l2_way, l2_ptr_new;
    logic [SW-1:0] ref_v, ref_way, ref_ptr_new;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign outcome   = outcome_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;

    assign cfg_static_bad =
        (l1_lines_reg == '0) || (l1_ways_reg == '0) ||
        (32'(l1_lines_reg) > 32'(L1_MAX_ENTRIES)) ||
        (l2_lines_reg == '0) || (l2_ways_reg == '0) ||
        (32'(l2_lines_reg) > 32'(L2_MAX_ENTRIES)) ||
        (block_bytes_reg == '0) || (32'(block_bytes_reg) > 32'(MAX_BLOCK_BYTES));

    assign div_trial = {div_r_reg[DW-1:0], div_q_reg[DW-1]};
    assign div_ge    = (div_trial >= {1'b0, div_d_reg});

    always_comb
    begin
        case (scan_sel_reg)
            SEL_L1:
            begin
                ways_cur = SW'(l1_ways_reg);
                tag_cur  = tag1_reg;
                rd_line  = l1_rd_reg;
            end
            SEL_L2:
            begin
                ways_cur = SW'(l2_ways_reg);
                tag_cur  = tag2_reg;
                rd_line  = l2_rd_reg;
            end
            default:
            begin
                ways_cur = SW'(l1_lines_reg);
                tag_cur  = blk_reg;
                rd_line  = ref_rd_reg;
            end
        endcase
    end

    assign scan_issue = (issue_idx_reg < ways_cur);
    assign scan_done  = !scan_issue && !pend_reg;
    assign seen_bit   = seen_rd_reg[blk_reg[4:0]];

    assign l1_v       = (SW'(l1p_rd_reg) >= SW'(l1_ways_reg)) ? '0 : SW'(l1p_rd_reg);
    assign l1_way     = l1_inv_found_reg ? l1_inv_way_reg : l1_v;
    assign l1_ptr_new = ((l1_v + SW'(1)) == SW'(l1_ways_reg)) ? '0 : (l1_v + SW'(1));
    assign l2_v       = (SW'(l2p_rd_reg) >= SW'(l2_ways_reg)) ? '0 : SW'(l2p_rd_reg);
    assign l2_way     = l2_inv_found_reg ? l2_inv_way_reg : l2_v;
    assign l2_ptr_new = ((l2_v + SW'(1)) == SW'(l2_ways_reg)) ? '0 : (l2_v + SW'(1));
    assign ref_v      = (SW'(ref_ptr_reg) >= SW'(l1_lines_reg)) ? '0 : SW'(ref_ptr_reg);
    assign ref_way    = inv_found_reg ? inv_way_reg : ref_v;
    assign ref_ptr_new = ((ref_v + SW'(1)) == SW'(l1_lines_reg)) ? '0 : (ref_v + SW'(1));

    assign l1_ra  = base1_reg + L1_AW'(issue_idx_reg);
    assign l2_ra  = base2_reg + L2_AW'(issue_idx_reg);
    assign ref_ra = L1_AW'(issue_idx_reg);

    always_comb
    begin
        l1_we   = 1'b0;
        l2_we   = 1'b0;
        ref_we  = 1'b0;
        l1p_we  = 1'b0;
        l2p_we  = 1'b0;
        seen_we = 1'b0;
        l1_wa   = base1_reg + L1_AW'(l1_way);
        l2_wa   = base2_reg + L2_AW'(l2_way);
        ref_wa  = L1_AW'(ref_way);
        l1p_wa  = set1_reg;
        l2p_wa  = set2_reg;
        seen_wa = blk_reg[ADDR_BITS-1:5];
        l1_wd   = {1'b1, tag1_reg};
        l2_wd   = {1'b1, tag2_reg};
        ref_wd  = {1'b1, blk_reg};
        l1p_wd  = L1_AW'(l1_ptr_new);
        l2p_wd  = L2_AW'(l2_ptr_new);
        seen_wd = seen_rd_reg | (32'd1 << blk_reg[4:0]);
        unique case (state_reg)
            S_CLR:
            begin
                l1_we   = 1'b1;
                l2_we   = 1'b1;
                ref_we  = 1'b1;
                l1p_we  = 1'b1;
                l2p_we  = 1'b1;
                seen_we = 1'b1;
                l1_wa   = clr_cnt_reg[L1_AW-1:0];
                l2_wa   = clr_cnt_reg[L2_AW-1:0];
                ref_wa  = clr_cnt_reg[L1_AW-1:0];
                l1p_wa  = clr_cnt_reg[L1_AW-1:0];
                l2p_wa  = clr_cnt_reg[L2_AW-1:0];
                seen_wa = clr_cnt_reg[SEEN_AW-1:0];
                l1_wd   = '0;
                l2_wd   = '0;
                ref_wd  = '0;
                l1p_wd  = '0;
                l2p_wd  = '0;
                seen_wd = '0;
            end
            S_SCAN:
            begin
                seen_we = scan_done && (scan_sel_reg == SEL_REF);
            end
            S_FILLR:
            begin
                ref_we = 1'b1;
            end
            S_FILL2:
            begin
                l2_we  = 1'b1;
                l2p_we = !l2_inv_found_reg;
            end
            S_FILL1:
            begin
                l1_we  = 1'b1;
                l1p_we = !l1_inv_found_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (l1_we)
        begin
            l1_mem[l1_wa] <= l1_wd;
        end
        l1_rd_reg <= l1_mem[l1_ra];
    end

    always_ff @(posedge clk)
    begin
        if (l2_we)
        begin
            l2_mem[l2_wa] <= l2_wd;
        end
        l2_rd_reg <= l2_mem[l2_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_wa] <= ref_wd;
        end
        ref_rd_reg <= ref_mem[ref_ra];
    end

    always_ff @(posedge clk)
    begin
        if (l1p_we)
        begin
            l1p_mem[l1p_wa] <= l1p_wd;
        end
        l1p_rd_reg <= l1p_mem[set1_reg];
    end

    always_ff @(posedge clk)
    begin
        if (l2p_we)
        begin
            l2p_mem[l2p_wa] <= l2p_wd;
        end
        l2p_rd_reg <= l2p_mem[set2_reg];
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_wa] <= seen_wd;
        end
        seen_rd_reg <= seen_mem[blk_reg[ADDR_BITS-1:5]];
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[PADDR_W-1:2]))
            REG_L1_LINES:    prdata = PDATA_W'(l1_lines_reg);
            REG_L1_WAYS:     prdata = PDATA_W'(l1_ways_reg);
            REG_L2_LINES:    prdata = PDATA_W'(l2_lines_reg);
            REG_L2_WAYS:     prdata = PDATA_W'(l2_ways_reg);
            REG_BLOCK_BYTES: prdata = PDATA_W'(block_bytes_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_lines_reg     <= RST_L1_LINES;
            l1_ways_reg      <= RST_L1_WAYS;
            l2_lines_reg     <= RST_L2_LINES;
            l2_ways_reg      <= RST_L2_WAYS;
            block_bytes_reg  <= RST_BLOCK_BYTES;
            state_reg        <= S_CLR;
            clr_cnt_reg      <= '0;
            step_reg         <= DIV_S1;
            out_valid_reg    <= 1'b0;
            outcome_reg      <= OUT_HIT_L1;
            code_reg         <= OUT_HIT_L1;
            div_q_reg        <= '0;
            div_r_reg        <= '0;
            div_d_reg        <= '0;
            div_cnt_reg      <= '0;
            addr_reg         <= '0;
            blk_reg          <= '0;
            s1_reg           <= '0;
            s2_reg           <= '0;
            set1_reg         <= '0;
            set2_reg         <= '0;
            tag1_reg         <= '0;
            tag2_reg         <= '0;
            base1_reg        <= '0;
            base2_reg        <= '0;
            scan_sel_reg     <= SEL_L1;
            issue_idx_reg    <= '0;
            pend_reg         <= 1'b0;
            pend_way_reg     <= '0;
            hit_reg          <= 1'b0;
            inv_found_reg    <= 1'b0;
            inv_way_reg      <= '0;
            l1_inv_found_reg <= 1'b0;
            l1_inv_way_reg   <= '0;
            l2_inv_found_reg <= 1'b0;
            l2_inv_way_reg   <= '0;
            ref_ptr_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
                    ref_ptr_reg <= '0;
                    if (clr_cnt_reg == {CLR_W{1'b1}})
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        addr_reg <= ADDR_BITS'(byte_address);
                        if (cfg_static_bad)
                        begin
                            code_reg  <= OUT_BAD_CFG;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            div_q_reg   <= DW'(l1_lines_reg);
                            div_d_reg   <= DW'(l1_ways_reg);
                            div_r_reg   <= '0;
                            div_cnt_reg <= '0;
                            step_reg    <= DIV_S1;
                            state_reg   <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_cnt_reg != DCW'(DW))
                    begin
                        div_r_reg   <= div_ge ? (div_trial - {1'b0, div_d_reg}) : div_trial;
                        div_q_reg   <= {div_q_reg[DW-2:0], div_ge};
                        div_cnt_reg <= div_cnt_reg + DCW'(1);
                    end
                    else
                    begin
                        div_r_reg   <= '0;
                        div_cnt_reg <= '0;
                        case (step_reg)
                            DIV_S1:
                            begin
                                if (div_r_reg != '0)
                                begin
                                    code_reg  <= OUT_BAD_CFG;
                                    state_reg <= S_OUT;
                                end
                                s1_reg    <= L1_ENT_W'(div_q_reg);
                                div_q_reg <= DW'(l2_lines_reg);
                                div_d_reg <= DW'(l2_ways_reg);
                                step_reg  <= DIV_S2;
                            end
                            DIV_S2:
                            begin
                                if (div_r_reg != '0)
                                begin
                                    code_reg  <= OUT_BAD_CFG;
                                    state_reg <= S_OUT;
                                end
                                s2_reg    <= L2_ENT_W'(div_q_reg);
                                div_q_reg <= DW'(addr_reg);
                                div_d_reg <= DW'(block_bytes_reg);
                                step_reg  <= DIV_BLK;
                            end
                            DIV_BLK:
                            begin
                                blk_reg   <= ADDR_BITS'(div_q_reg);
                                div_q_reg <= div_q_reg;
                                div_d_reg <= DW'(s1_reg);
                                step_reg  <= DIV_SET1;
                            end
                            DIV_SET1:
                            begin
                                tag1_reg  <= TAG_W'(div_q_reg);
                                set1_reg  <= L1_AW'(div_r_reg);
                                div_q_reg <= DW'(blk_reg);
                                div_d_reg <= DW'(s2_reg);
                                step_reg  <= DIV_SET2;
                            end
                            DIV_SET2:
                            begin
                                tag2_reg  <= TAG_W'(div_q_reg);
                                set2_reg  <= L2_AW'(div_r_reg);
                                state_reg <= S_BASE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_BASE:
                begin
                    base1_reg     <= L1_AW'(set1_reg * l1_ways_reg);
                    base2_reg     <= L2_AW'(set2_reg * l2_ways_reg);
                    scan_sel_reg  <= SEL_L1;
                    issue_idx_reg <= '0;
                    pend_reg      <= 1'b0;
                    hit_reg       <= 1'b0;
                    inv_found_reg <= 1'b0;
                    state_reg     <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_issue)
                    begin
                        issue_idx_reg <= issue_idx_reg + SW'(1);
                    end
                    pend_reg     <= scan_issue;
                    pend_way_reg <= issue_idx_reg;
                    if (pend_reg)
                    begin
                        if (rd_line[LINE_W-1] && (rd_line[TAG_W-1:0] == tag_cur))
                        begin
                            hit_reg <= 1'b1;
                        end
                        if (!rd_line[LINE_W-1] && !inv_found_reg)
                        begin
                            inv_found_reg <= 1'b1;
                            inv_way_reg   <= pend_way_reg;
                        end
                    end
                    if (scan_done)
                    begin
                        issue_idx_reg <= '0;
                        hit_reg       <= 1'b0;
                        inv_found_reg <= 1'b0;
                        case (scan_sel_reg)
                            SEL_L1:
                            begin
                                l1_inv_found_reg <= inv_found_reg;
                                l1_inv_way_reg   <= inv_way_reg;
                                if (hit_reg)
                                begin
                                    code_reg  <= OUT_HIT_L1;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    scan_sel_reg <= SEL_L2;
                                end
                            end
                            SEL_L2:
                            begin
                                l2_inv_found_reg <= inv_found_reg;
                                l2_inv_way_reg   <= inv_way_reg;
                                if (hit_reg)
                                begin
                                    code_reg  <= OUT_HIT_L2;
                                    state_reg <= S_FILL1;
                                end
                                else
                                begin
                                    scan_sel_reg <= SEL_REF;
                                end
                            end
                            default:
                            begin
                                // keep the reference scan result for its fill
                                inv_found_reg <= inv_found_reg;
                                if (!seen_bit)
                                begin
                                    code_reg <= OUT_COMPULSORY;
                                end
                                else if (hit_reg)
                                begin
                                    code_reg <= OUT_CONFLICT;
                                end
                                else
                                begin
                                    code_reg <= OUT_CAPACITY;
                                end
                                state_reg <= S_FILLR;
                            end
                        endcase
                    end
                end
                S_FILLR:
                begin
                    if (!inv_found_reg)
                    begin
                        ref_ptr_reg <= L1_AW'(ref_ptr_new);
                    end
                    state_reg <= S_FILL2;
                end
                S_FILL2:
                begin
                    state_reg <= S_FILL1;
                end
                S_FILL1:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        outcome_reg   <= code_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_CLR;
                end
            endcase

            if (cfg_wr)
            begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_L1_LINES:
                    begin
                        l1_lines_reg <= pwdata[L1_ENT_W-1:0];
                        state_reg    <= S_CLR;
                        clr_cnt_reg  <= '0;
                    end
                    REG_L1_WAYS:
                    begin
                        l1_ways_reg <= pwdata[L1_WAY_W-1:0];
                        state_reg   <= S_CLR;
                        clr_cnt_reg <= '0;
                    end
                    REG_L2_LINES:
                    begin
                        l2_lines_reg <= pwdata[L2_ENT_W-1:0];
                        state_reg    <= S_CLR;
                        clr_cnt_reg  <= '0;
                    end
                    REG_L2_WAYS:
                    begin
                        l2_ways_reg <= pwdata[L2_WAY_W-1:0];
                        state_reg   <= S_CLR;
                        clr_cnt_reg <= '0;
                    end
                    REG_BLOCK_BYTES:
                    begin
                        block_bytes_reg <= pwdata[BLK_W-1:0];
                        state_reg       <= S_CLR;
                        clr_cnt_reg     <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- bench/tlcmc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcmc_checker
// watches the input, output and register channels of the two-level cache
// miss classifier, keeps its own copy of the tag stores, predicts the outcome
// of every accepted address and compares it with each accepted outcome
// ----------------------------------------------------------------------------
module tlcmc_checker
    import tlcmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [IN_W-1:0]    byte_address,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [OUT_W-1:0]   outcome,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 pending,
    output int                 fails
);

    // flat tag stores: L1 lines, then L2 lines, then the reference store
    localparam int L1_OFS  = 0;
    localparam int L2_OFS  = DEF_L1_MAX_ENTRIES;
    localparam int REF_OFS = DEF_L1_MAX_ENTRIES + DEF_L2_MAX_ENTRIES;
    localparam int LINES   = REF_OFS + DEF_L1_MAX_ENTRIES;

    bit          line_valid [LINES];
    int unsigned line_tag   [LINES];
    int unsigned victim_ptr [LINES];
    bit          seen_block [1 << DEF_ADDR_BITS];
    int unsigned l1_lines, l1_ways, l2_lines, l2_ways, block_bytes;
    outcome_t    outcomes_due [$];

    function automatic void clear_stores();
        line_valid = '{default: 0};
        line_tag   = '{default: 0};
        victim_ptr = '{default: 0};
        seen_block = '{default: 0};
    endfunction

    function automatic bit tag_lookup(int ofs, int unsigned sets, int unsigned ways,
                                      int unsigned blk);
        int unsigned base;
        base = ofs + (blk % sets) * ways;
        for (int unsigned w = 0; w < ways; w++)
            if (line_valid[base + w] && line_tag[base + w] == blk / sets)
                return 1;
        return 0;
    endfunction

    function automatic void tag_fill(int ofs, int unsigned sets, int unsigned ways,
                                     int unsigned blk);
        int unsigned set_no, base, v;
        set_no = blk % sets;
        base   = ofs + set_no * ways;
        for (int unsigned w = 0; w < ways; w++)
            if (!line_valid[base + w]) begin
                line_valid[base + w] = 1;
                line_tag[base + w]   = blk / sets;
                return;
            end
        v = victim_ptr[ofs + set_no];
        if (v >= ways)
            v = 0;
        line_valid[base + v] = 1;
        line_tag[base + v]   = blk / sets;
        victim_ptr[ofs + set_no] = (v + 1) % ways;
    endfunction

    function automatic outcome_t classify_access(logic [IN_W-1:0] addr);
        int unsigned s1, s2, blk;
        outcome_t    code;
        if (l1_lines == 0 || l1_ways == 0 || l1_lines > DEF_L1_MAX_ENTRIES ||
            l1_lines % l1_ways != 0 || l2_lines == 0 || l2_ways == 0 ||
            l2_lines > DEF_L2_MAX_ENTRIES || l2_lines % l2_ways != 0 ||
            block_bytes == 0 || block_bytes > DEF_MAX_BLOCK_BYTES)
            return OUT_BAD_CFG;
        s1  = l1_lines / l1_ways;
        s2  = l2_lines / l2_ways;
        blk = addr / block_bytes;
        if (tag_lookup(L1_OFS, s1, l1_ways, blk))
            return OUT_HIT_L1;
        if (tag_lookup(L2_OFS, s2, l2_ways, blk)) begin
            tag_fill(L1_OFS, s1, l1_ways, blk);
            return OUT_HIT_L2;
        end
        if (!seen_block[blk]) begin
            code = OUT_COMPULSORY;
            seen_block[blk] = 1;
        end
        else if (tag_lookup(REF_OFS, 1, l1_lines, blk))
            code = OUT_CONFLICT;
        else
            code = OUT_CAPACITY;
        tag_fill(REF_OFS, 1, l1_lines, blk);
        tag_fill(L2_OFS, s2, l2_ways, blk);
        tag_fill(L1_OFS, s1, l1_ways, blk);
        return code;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        outcome_t want;
        if (!rst_n) begin
            l1_lines    = RST_L1_LINES;
            l1_ways     = RST_L1_WAYS;
            l2_lines    = RST_L2_LINES;
            l2_ways     = RST_L2_WAYS;
            block_bytes = RST_BLOCK_BYTES;
            clear_stores();
            outcomes_due.delete();
            fails   = 0;
            pending = 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] <= REG_BLOCK_BYTES)
            begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_L1_LINES:    l1_lines    = pwdata[L1_ENT_W-1:0];
                    REG_L1_WAYS:     l1_ways     = pwdata[L1_WAY_W-1:0];
                    REG_L2_LINES:    l2_lines    = pwdata[L2_ENT_W-1:0];
                    REG_L2_WAYS:     l2_ways     = pwdata[L2_WAY_W-1:0];
                    REG_BLOCK_BYTES: block_bytes = pwdata[BLK_W-1:0];
                    default: ;
                endcase
                clear_stores();
            end
            if (out_valid && out_ready) begin
                if (outcomes_due.size() == 0) begin
                    $error("unexpected outcome transaction: outcome %0d", outcome);
                    fails++;
                end
                else begin
                    want = outcomes_due.pop_front();
                    if (outcome !== want) begin
                        $error("outcome mismatch: expected %0d, actual %0d", want, outcome);
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
                outcomes_due.push_back(classify_access(byte_address));
            pending = outcomes_due.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives addresses and register writes into the two-level cache miss
// classifier under several cache geometries, bad settings and idle patterns;
// the checker beside the block predicts and compares every outcome
// ----------------------------------------------------------------------------
module tb;
    import tlcmc_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [IN_W-1:0]    byte_address;
    logic               out_valid;
    logic               out_ready;
    logic [OUT_W-1:0]   outcome;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 pending;
    int                 fails;

    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_off;
    logic [IN_W-1:0]    addr_pool [$];

    two_level_cache_miss_classifier_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_address (byte_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .outcome      (outcome),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tlcmc_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_address (byte_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .outcome      (outcome),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pending      (pending),
        .fails        (fails)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls, or a long hold-off counted here
    initial begin
        out_ready = 0;
        forever begin
            @(posedge clk);
            if (hold_off > 0) begin
                hold_off  <= hold_off - 1;
                out_ready <= 0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_address(input logic [IN_W-1:0] addr);
        bit ok;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid     <= 1;
        byte_address <= addr;
        do begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end while (!ok);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int e1, input int w1, input int e2, input int w2,
                                input int bb);
        drain();
        reg_write(REG_L1_LINES, e1);
        reg_write(REG_L1_WAYS, w1);
        reg_write(REG_L2_LINES, e2);
        reg_write(REG_L2_WAYS, w2);
        reg_write(REG_BLOCK_BYTES, bb);
    endtask

    // mostly reuse of a small working set, some fully random addresses
    task automatic random_phase(input int count, input int l1_size);
        int pool_size;
        pool_size = $urandom_range(1, 3 * l1_size + 2);
        addr_pool.delete();
        repeat (pool_size) addr_pool.push_back(IN_W'($urandom));
        repeat (count) begin
            if ($urandom_range(99) < 85)
                send_address(addr_pool[$urandom_range(pool_size - 1)]);
            else
                send_address(IN_W'($urandom));
        end
    endtask

    initial begin
        int w1, s1, w2, s2, bb;
        rst_n          = 0;
        in_valid       = 0;
        byte_address   = '0;
        psel           = 0;
        penable        = 0;
        pwrite         = 0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset geometry: compulsory misses, L1 hits and L2 hits
        send_address(16'h0000);
        send_address(16'hFFFF);
        send_address(16'h0004);
        send_address(16'h0080);
        send_address(16'h0100);
        send_address(16'h0180);
        send_address(16'h0000);
        send_address(16'h0200);
        send_address(16'h0300);
        send_address(16'h0000);

        // bad settings, each followed by one access
        set_geometry(0, 2, 128, 4, 16);
        send_address(16'h1234);
        set_geometry(16, 3, 128, 4, 16);
        send_address(16'h1234);
        set_geometry(16, 0, 128, 4, 16);
        send_address(16'h1234);
        set_geometry(100, 4, 128, 4, 16);
        send_address(16'h1234);
        set_geometry(16, 2, 0, 4, 16);
        send_address(16'h1234);
        set_geometry(16, 2, 1020, 4, 16);
        send_address(16'h1234);
        set_geometry(16, 2, 128, 0, 16);
        send_address(16'h1234);
        set_geometry(16, 2, 128, 3, 16);
        send_address(16'h1234);
        set_geometry(16, 2, 128, 4, 0);
        send_address(16'h1234);
        set_geometry(16, 2, 128, 4, 300);
        send_address(16'h1234);

        // value bits above the register width and a write beyond the map
        set_geometry(32'hFFFF_FF90, 32'hFFFF_FF81, 32'hFFFF_FC80, 32'hFFFF_FC04,
                     32'hFFFF_FE10);
        reg_write(reg_idx_t'(5), 32'hFFFF_FFFF);
        send_address(16'h0010);
        send_address(16'h0010);

        // largest geometry
        set_geometry(64, 64, 512, 512, 256);
        for (int i = 0; i < 40; i++)
            send_address(IN_W'((i % 20) * 256 + i));
        // smallest geometry, one-byte blocks
        set_geometry(1, 1, 1, 1, 1);
        send_address(16'hFFFF);
        send_address(16'h0000);
        send_address(16'hFFFF);
        random_phase(30, 1);

        // random geometries through every idle pattern
        for (int ph = 0; ph < 8; ph++) begin
            w1 = $urandom_range(1, 8);
            s1 = $urandom_range(1, 64 / w1);
            w2 = $urandom_range(1, 16);
            s2 = $urandom_range(1, 64 / w2);
            bb = ($urandom_range(1) == 1) ? (1 << $urandom_range(8)) : $urandom_range(1, 256);
            set_geometry(w1 * s1, w1, w2 * s2, w2, bb);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (ph == 5)
                hold_off = 3000;
            random_phase(40, w1 * s1);
        end

        drain();
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/tlcmc_pkg.sv
design/two_level_cache_miss_classifier_unit.sv
bench/tlcmc_checker.sv
bench/tb.sv
